>>> sv/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  // thread states as kept in the table
  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;
  localparam logic [1:0] OP_JOIN   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_NONE  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] target_thread;
  } rrts_cmd_t;

  typedef struct packed {
    logic [6:0] running_thread;
    logic [6:0] new_thread;
    logic [1:0] status;
  } rrts_result_t;

endpackage

`default_nettype wire

>>> sv/rrts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/rrts_wrap_inc.sv
`timescale 1ns / 1ps
`default_nettype none

// round-robin step: next id after cand, wrapping to zero at limit
module rrts_wrap_inc #(
  parameter int ID_W  = 7,
  parameter int NID_W = 8
) (
  input  wire logic [ID_W-1:0]  cand,
  input  wire logic [NID_W-1:0] limit,
  output logic      [ID_W-1:0]  next
);

  logic [NID_W:0] sum;

  assign sum  = (NID_W + 1)'(cand) + (NID_W + 1)'(1);
  assign next = (sum >= {1'b0, limit}) ? '0 : sum[ID_W-1:0];

endmodule

`default_nettype wire

>>> sv/round_robin_thread_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// round-robin thread scheduler with join
//
// usage: drive cmd and raise start while busy is low; that edge is the
// transfer of one command. busy stays high until the command is finished.
// exactly one result per command appears on result with done high for a
// single cycle; the receiver cannot hold it off, so it must take it then.
// a new command may be started in the same cycle that done is high.
//
// create, and join on an out-of-range target, finish from idle; join on a
// dead target ends at the target check. tick scans; exit kills the current
// thread, wakes any joiner, then scans; join on a live target blocks the
// caller, marks the target, then scans. the scan reads one table entry per
// cycle from the thread table ram; its length is set by the created threads.
//
// reset: thread 0 is ready and current, next free id is 1. the table ram is
// not cleared; entries at or above next_id read as dead and entry 0 reads
// as ready until first written, so no clearing pass is needed.
module round_robin_thread_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire rrts_cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output rrts_result_t      result
);

  localparam int ID_W  = $clog2(MAX_THREADS);
  localparam int NID_W = $clog2(MAX_THREADS + 1);
  localparam int REC_W = ID_W + 3;

  localparam logic [NID_W-1:0] MAX_N   = NID_W'(MAX_THREADS);
  localparam logic [NID_W+6:0] MAX_TGT = (NID_W + 7)'(MAX_THREADS);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EX_RD     = 4'd1;
  localparam logic [3:0] S_EX_WK_ISS = 4'd2;
  localparam logic [3:0] S_EX_WK_WR  = 4'd3;
  localparam logic [3:0] S_JN_CHK    = 4'd4;
  localparam logic [3:0] S_JN_CUR    = 4'd5;
  localparam logic [3:0] S_JN_TISS   = 4'd6;
  localparam logic [3:0] S_JN_TWR    = 4'd7;
  localparam logic [3:0] S_SC_INIT   = 4'd8;
  localparam logic [3:0] S_SCAN      = 4'd9;

  logic [3:0]       state;
  logic [ID_W-1:0]  current;
  logic [NID_W-1:0] next_id;
  logic             e0_written;   // entry 0 holds real data in the ram
  logic [ID_W-1:0]  tgt_q;
  logic [ID_W-1:0]  j_q;
  logic [ID_W-1:0]  scan_addr;
  logic [NID_W-1:0] issue_left;
  logic [NID_W-1:0] chk_left;
  logic             chk_vld;
  logic [ID_W-1:0]  rd_addr_q;

  // ram port signals
  logic             we;
  logic [ID_W-1:0]  waddr;
  logic [REC_W-1:0] wdata;
  logic             re;
  logic [ID_W-1:0]  raddr;
  logic [REC_W-1:0] rd_data;

  // table record as seen after the fill-count and entry-0 fixups
  logic [1:0]       rec_st;
  logic             rec_jv;
  logic [ID_W-1:0]  rec_jid;
  logic             rec_beyond;
  logic             rec_e0_fresh;

  // command decode
  logic [ID_W+6:0]  tgt_ext;
  logic [NID_W+6:0] tgt_w;
  logic [ID_W-1:0]  tgt_idx;
  logic             tgt_in_range;
  logic             table_full;
  logic             accept;

  // shared round-robin incrementer
  logic [ID_W-1:0]  inc_in;
  logic [ID_W-1:0]  inc_out;

  // ids reported modulo 128
  logic [ID_W+6:0]  cur_ext;
  logic [NID_W+6:0] nid_ext;
  logic [ID_W+6:0]  chk_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign tgt_ext      = {{ID_W{1'b0}}, cmd.target_thread};
  assign tgt_idx      = tgt_ext[ID_W-1:0];
  assign tgt_w        = {{NID_W{1'b0}}, cmd.target_thread};
  assign tgt_in_range = (tgt_w < MAX_TGT);
  assign table_full   = (next_id >= MAX_N);

  assign cur_ext = {7'd0, current};
  assign nid_ext = {7'd0, next_id};
  assign chk_ext = {7'd0, rd_addr_q};

  assign rec_beyond   = (NID_W'(rd_addr_q) >= next_id);
  assign rec_e0_fresh = (rd_addr_q == '0) && !e0_written;

  always_comb begin
    priority if (rec_beyond) begin
      rec_st  = ST_DEAD;
      rec_jv  = 1'b0;
      rec_jid = '0;
    end else if (rec_e0_fresh) begin
      rec_st  = ST_READY;
      rec_jv  = 1'b0;
      rec_jid = '0;
    end else begin
      rec_st  = rd_data[REC_W-1:REC_W-2];
      rec_jv  = rd_data[ID_W];
      rec_jid = rd_data[ID_W-1:0];
    end
  end

  // the incrementer seeds the scan from the current thread, then walks it
  assign inc_in = (state == S_SC_INIT) ? current : scan_addr;

  rrts_wrap_inc #(
    .ID_W  (ID_W),
    .NID_W (NID_W)
  ) u_wrap_inc (
    .cand  (inc_in),
    .limit (next_id),
    .next  (inc_out)
  );

  // table accesses; exit, wake and join updates read then write the record
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.operation == OP_CREATE && !table_full) begin
            we    = 1'b1;
            waddr = next_id[ID_W-1:0];
            wdata = {ST_READY, 1'b0, {ID_W{1'b0}}};
          end else if (cmd.operation == OP_EXIT) begin
            re    = 1'b1;
            raddr = current;
          end else if (cmd.operation == OP_JOIN && tgt_in_range) begin
            re    = 1'b1;
            raddr = tgt_idx;
          end
        end
      end
      S_EX_RD: begin
        // exiting thread dies, its joiner slot is released
        we    = 1'b1;
        waddr = current;
        wdata = {ST_DEAD, 1'b0, rec_jid};
      end
      S_EX_WK_ISS: begin
        re    = 1'b1;
        raddr = j_q;
      end
      S_EX_WK_WR: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = {ST_READY, rec_jv, rec_jid};
      end
      S_JN_CHK: begin
        if (rec_st != ST_DEAD) begin
          re    = 1'b1;
          raddr = current;
        end
      end
      S_JN_CUR: begin
        we    = 1'b1;
        waddr = current;
        wdata = {ST_BLOCKED, rec_jv, rec_jid};
      end
      S_JN_TISS: begin
        re    = 1'b1;
        raddr = tgt_q;
      end
      S_JN_TWR: begin
        // target re-read after the block so a self-join keeps both updates
        we    = 1'b1;
        waddr = tgt_q;
        wdata = {rec_st, 1'b1, current};
      end
      S_SCAN: begin
        if (issue_left != '0) begin
          re    = 1'b1;
          raddr = scan_addr;
        end
      end
      default: begin
      end
    endcase
  end

  rrts_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_THREADS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (re) begin
      rd_addr_q <= raddr;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      current    <= '0;
      next_id    <= NID_W'(1);
      e0_written <= 1'b0;
      done       <= 1'b0;
      chk_vld    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (we && waddr == '0) begin
        e0_written <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tgt_q <= tgt_idx;
            unique case (cmd.operation)
              OP_TICK: begin
                state <= S_SC_INIT;
              end
              OP_CREATE: begin
                done                  <= 1'b1;
                result.running_thread <= cur_ext[6:0];
                if (table_full) begin
                  result.new_thread <= 7'd0;
                  result.status     <= STAT_LIMIT;
                end else begin
                  result.new_thread <= nid_ext[6:0];
                  result.status     <= STAT_OK;
                  next_id           <= next_id + NID_W'(1);
                end
              end
              OP_EXIT: begin
                state <= S_EX_RD;
              end
              OP_JOIN: begin
                if (tgt_in_range) begin
                  state <= S_JN_CHK;
                end else begin
                  // a target outside the table counts as dead
                  done                  <= 1'b1;
                  result.running_thread <= cur_ext[6:0];
                  result.new_thread     <= 7'd0;
                  result.status         <= STAT_OK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EX_RD: begin
          j_q <= rec_jid;
          if (rec_jv) begin
            state <= S_EX_WK_ISS;
          end else begin
            state <= S_SC_INIT;
          end
        end
        S_EX_WK_ISS: begin
          state <= S_EX_WK_WR;
        end
        S_EX_WK_WR: begin
          state <= S_SC_INIT;
        end
        S_JN_CHK: begin
          if (rec_st == ST_DEAD) begin
            // join on a dead thread: nothing changes, no scheduling
            done                  <= 1'b1;
            result.running_thread <= cur_ext[6:0];
            result.new_thread     <= 7'd0;
            result.status         <= STAT_OK;
            state                 <= S_IDLE;
          end else begin
            state <= S_JN_CUR;
          end
        end
        S_JN_CUR: begin
          state <= S_JN_TISS;
        end
        S_JN_TISS: begin
          state <= S_JN_TWR;
        end
        S_JN_TWR: begin
          state <= S_SC_INIT;
        end
        S_SC_INIT: begin
          // scan starts just after the current thread, which comes last
          scan_addr  <= inc_out;
          issue_left <= next_id;
          chk_left   <= next_id;
          chk_vld    <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          // one read issued and one read checked per cycle
          if (issue_left != '0) begin
            scan_addr  <= inc_out;
            issue_left <= issue_left - NID_W'(1);
          end
          chk_vld <= (issue_left != '0);
          if (chk_vld) begin
            chk_left <= chk_left - NID_W'(1);
            if (rec_st == ST_READY) begin
              current               <= rd_addr_q;
              done                  <= 1'b1;
              result.running_thread <= chk_ext[6:0];
              result.new_thread     <= 7'd0;
              result.status         <= STAT_OK;
              chk_vld               <= 1'b0;
              state                 <= S_IDLE;
            end else if (chk_left == NID_W'(1)) begin
              // nothing ready: current thread stays as it is
              done                  <= 1'b1;
              result.running_thread <= cur_ext[6:0];
              result.new_thread     <= 7'd0;
              result.status         <= STAT_NONE;
              chk_vld               <= 1'b0;
              state                 <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the free id never runs past the table and is never zero
  a_next_id_range: assert property (@(posedge clk) disable iff (rst)
    (next_id != '0) && (next_id <= MAX_N))
    else $error("next_id out of range");

  // the scheduler only ever selects a thread that has been created
  a_current_created: assert property (@(posedge clk) disable iff (rst)
    NID_W'(current) < next_id)
    else $error("current thread beyond allocated ids");

  // a scan never checks more entries than were issued
  a_scan_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (chk_left != '0) && (issue_left <= chk_left))
    else $error("scan counters out of step");

  // a refused create hands out no id and leaves next_id alone
  a_limit_no_id: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_LIMIT) |->
      (result.new_thread == 7'd0) && $stable(next_id))
    else $error("create at limit changed state");

  // busy only rises from a started command
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");
`endif

endmodule

`default_nettype wire
